// File: design/lmfs_pkg.sv
// Package for the LED matrix flash scanner.
// Holds the word kinds, item struct, field widths and reset constants; no dependencies.
package lmfs_pkg;

    localparam int unsigned ROWS        = 4;
    localparam int unsigned ROW_W       = 2;
    localparam int unsigned COLS        = 16;
    localparam int unsigned COL_W       = 4;
    localparam int unsigned INDEX_W     = 6;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned FLASH_W     = 3;
    localparam int unsigned TEST_W      = 4;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 24;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [TEST_W-1:0] TEST_TICKS = 4'd10;

    typedef enum logic [1:0] {
        KIND_SET_LED = 2'd0,
        KIND_SCAN    = 2'd1,
        KIND_FLASH   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [INDEX_W-1:0]   led_index;
        logic [MODE_W-1:0]    led_mode;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COLS-1:0]  column_bits;
        logic             row_enable;
    } result_t;

endpackage

// File: design/led_matrix_flash_scanner_top.sv
// Top level of the LED matrix flash scanner: stream ports, APB register, core.
// Instantiates lmfs_in_stage and lmfs_core; depends on lmfs_pkg.
//
// Scans a 4 x 16 LED matrix with two flash phases. Input words carry kind in
// s_tuser (0 set LED, 1 scan tick, 2 flash tick; 3 is dropped) and the LED
// number and mode in s_tdata. Every scan tick yields one output word with the
// new row, its 16 column bits and the row enable; other kinds yield nothing.
// One input word is taken per clock while no scan word waits. A scan result is
// offered on m_tvalid once its word has passed the input register and the update
// logic has loaded the output register. Only a scan word waits on a full, unread
// output register; set-LED and flash words keep flowing. The column bits read all
// ones for the first TEST_TICKS (default ten) flash ticks after reset (lamp test).
// Register leds_enabled sits at APB addresses 0 to 3 (only paddr[2] decoded), reset value 1.
module led_matrix_flash_scanner_top #(
    parameter logic [lmfs_pkg::TEST_W-1:0] TEST_TICKS = lmfs_pkg::TEST_TICKS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lmfs_pkg::S_TDATA_W-1:0]    s_tdata,   // led_index[5:0], led_mode[7:6]
    input  logic [lmfs_pkg::S_TUSER_W-1:0]    s_tuser,   // kind[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lmfs_pkg::M_TDATA_W-1:0]    m_tdata,   // row[1:0], column_bits[17:2],
                                                         // row_enable[18], zeros[23:19]
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lmfs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lmfs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lmfs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lmfs_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    item_take;
    result_t result;
    logic    leds_enabled_reg;
    logic    leds_enabled_next;
    logic    reg0_sel;

    assign pready   = 1'b1;
    assign reg0_sel = (paddr[APB_ADDR_W-1] == 1'b0);

    always_comb begin
        leds_enabled_next = leds_enabled_reg;
        if (psel && penable && pwrite && pready && reg0_sel) begin
            leds_enabled_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leds_enabled_reg <= 1'b1;
        end else begin
            leds_enabled_reg <= leds_enabled_next;
        end
    end

    assign prdata = reg0_sel ? {{(APB_DATA_W-1){1'b0}}, leds_enabled_reg} : '0;

    lmfs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    lmfs_core #(
        .TEST_TICKS (TEST_TICKS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .leds_enabled (leds_enabled_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result       (result)
    );

    assign m_tdata = {{(M_TDATA_W-ROW_W-COLS-1){1'b0}},
                      result.row_enable, result.column_bits, result.row};

endmodule

// File: design/lmfs_in_stage.sv
// Input register for the LED matrix flash scanner.
// Captures one word per cycle while its register is empty or taken; depends on lmfs_pkg.
module lmfs_in_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lmfs_pkg::S_TDATA_W-1:0]   s_tdata,   // led_index[5:0], led_mode[7:6]
    input  logic [lmfs_pkg::S_TUSER_W-1:0]   s_tuser,   // kind[1:0]
    output logic                             item_valid,
    output lmfs_pkg::item_t                  item,
    input  logic                             item_take
);
    import lmfs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind      <= kind_t'(s_tuser);
            item_reg.led_index <= s_tdata[INDEX_W-1:0];
            item_reg.led_mode  <= s_tdata[INDEX_W +: MODE_W];
        end
    end

endmodule

// File: design/lmfs_core.sv
// Pattern planes, scan and flash state, and result register of the LED matrix scanner.
// Processes one registered word per cycle unless a scan word waits on an unread result.
module lmfs_core #(
    parameter logic [lmfs_pkg::TEST_W-1:0] TEST_TICKS = lmfs_pkg::TEST_TICKS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  lmfs_pkg::item_t   item,
    output logic              item_take,
    input  logic              leds_enabled,
    output logic              out_valid,
    input  logic              out_ready,
    output lmfs_pkg::result_t result
);
    import lmfs_pkg::*;

    logic [COLS-1:0]    plane_a_reg [ROWS];
    logic [COLS-1:0]    plane_a_next[ROWS];
    logic [COLS-1:0]    plane_b_reg [ROWS];
    logic [COLS-1:0]    plane_b_next[ROWS];
    logic [ROW_W-1:0]   scan_row_reg;
    logic [ROW_W-1:0]   scan_row_next;
    logic [FLASH_W-1:0] flash_count_reg;
    logic [FLASH_W-1:0] flash_count_next;
    logic [TEST_W-1:0]  test_left_reg;
    logic [TEST_W-1:0]  test_left_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            result_reg;
    result_t            result_next;
    logic               load_result;
    logic [ROW_W-1:0]   wr_row;
    logic [COL_W-1:0]   wr_col;
    logic [COLS-1:0]    rd_bits;

    // LED n sits in byte n[5:3]; byte pairs form one 16-bit row
    assign wr_row = item.led_index[INDEX_W-1 -: ROW_W];
    assign wr_col = item.led_index[COL_W-1:0];

    assign item_take = item_valid &&
                       (item.kind != KIND_SCAN || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb begin
        plane_a_next     = plane_a_reg;
        plane_b_next     = plane_b_reg;
        scan_row_next    = scan_row_reg;
        flash_count_next = flash_count_reg;
        test_left_next   = test_left_reg;
        load_result      = 1'b0;
        rd_bits          = '0;
        if (item_take) begin
            case (item.kind)
                KIND_SET_LED: begin
                    plane_a_next[wr_row][wr_col] = item.led_mode[1];
                    plane_b_next[wr_row][wr_col] = item.led_mode[0];
                end
                KIND_FLASH: begin
                    flash_count_next = flash_count_reg + 1'b1;
                    if (test_left_reg != '0) begin
                        test_left_next = test_left_reg - 1'b1;
                    end
                end
                KIND_SCAN: begin
                    scan_row_next = scan_row_reg + 1'b1;
                    load_result   = 1'b1;
                end
                default: begin
                end
            endcase
        end
        rd_bits = flash_count_reg[FLASH_W-1] ? plane_b_reg[scan_row_next]
                                             : plane_a_reg[scan_row_next];
        result_next.row         = scan_row_next;
        result_next.column_bits = (test_left_reg != '0) ? '1 : rd_bits;
        result_next.row_enable  = leds_enabled;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_result) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROWS; i++) begin
                plane_a_reg[i] <= '0;
                plane_b_reg[i] <= '0;
            end
            scan_row_reg    <= '0;
            flash_count_reg <= '0;
            test_left_reg   <= TEST_TICKS;
            out_valid_reg   <= 1'b0;
        end else begin
            plane_a_reg     <= plane_a_next;
            plane_b_reg     <= plane_b_next;
            scan_row_reg    <= scan_row_next;
            flash_count_reg <= flash_count_next;
            test_left_reg   <= test_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_scan_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && item.kind == KIND_SCAN |=> out_valid_reg)
        else $error("scan tick produced no output word");

    a_flash_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && item.kind == KIND_FLASH
        |=> flash_count_reg == $past(flash_count_reg) + 1'b1)
        else $error("flash counter did not advance");

    a_test_all_on: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && item.kind == KIND_SCAN && test_left_reg != '0
        |=> result_reg.column_bits == '1)
        else $error("column bits not all on during lamp test");

    a_pending_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |-> !(item_take && item.kind == KIND_SCAN))
        else $error("scan taken while result word still pending");
`endif

endmodule

// File: sim/tb_top.sv
// Testbench for led_matrix_flash_scanner_top: stream words in, scan words out, APB register.
// Checks every scan word against an in-bench model of planes and counters or a fixed word.
// Depends on lmfs_pkg and the design files under design/.
module tb_top;
    import lmfs_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned WORDS_PER_PHASE = 210;
    localparam int unsigned HOLD_CYCLES     = 200;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned DIR_COUNT       = 25;

    localparam logic [APB_ADDR_W-1:0] ADDR_LEDS_EN = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE   = 3'd4;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_B_ONLY = 2'd1;
    localparam logic [1:0] MODE_A_ONLY = 2'd2;
    localparam logic [1:0] MODE_STEADY = 2'd3;

    localparam result_t NO_ROW    = '0;
    localparam result_t LAMP_ROW1 = '{2'd1, 16'hFFFF, 1'b1};
    localparam result_t LAMP_ROW2 = '{2'd2, 16'hFFFF, 1'b1};

    typedef struct {
        logic [1:0]         kind;
        logic [INDEX_W-1:0] idx;
        logic [MODE_W-1:0]  mode;
        bit                 has_res;
        result_t            res;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // led_index[5:0], led_mode[7:6]
    logic [S_TUSER_W-1:0]  s_tuser  = '0;   // kind[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // row[1:0], column_bits[17:2], row_enable[18]
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    logic [7:0]        phase_a [8];
    logic [7:0]        phase_b [8];
    logic [ROW_W-1:0]  cur_row   = '0;
    logic [FLASH_W-1:0] flash_cnt = '0;
    logic [TEST_W-1:0] lamp_left = TEST_TICKS;
    logic              leds_en   = 1'b1;

    result_t     scan_rows_due[$];
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;
    bit          rx_hold_req = 1'b0;

    logic [31:0] cfg_words [PHASES] = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                                        32'h1, 32'h0, 32'h1};

    stim_row_t dir_rows [DIR_COUNT] = '{
        '{KIND_SCAN,    6'd0,  MODE_OFF,    1'b1, LAMP_ROW1},
        '{KIND_SET_LED, 6'd0,  MODE_STEADY, 1'b0, NO_ROW},
        '{KIND_SET_LED, 6'd63, MODE_STEADY, 1'b0, NO_ROW},
        '{KIND_SET_LED, 6'd8,  MODE_A_ONLY, 1'b0, NO_ROW},
        '{KIND_SET_LED, 6'd15, MODE_B_ONLY, 1'b0, NO_ROW},
        '{KIND_SET_LED, 6'd56, MODE_OFF,    1'b0, NO_ROW},
        '{KIND_SCAN,    6'd63, MODE_STEADY, 1'b1, LAMP_ROW2},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd63, MODE_STEADY, 1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_SCAN,    6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_SCAN,    6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_SPARE,   6'd63, MODE_STEADY, 1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_FLASH,   6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_SCAN,    6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_SCAN,    6'd0,  MODE_OFF,    1'b0, NO_ROW},
        '{KIND_SCAN,    6'd0,  MODE_OFF,    1'b0, NO_ROW}
    };

    led_matrix_flash_scanner_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic bit idle_now(input bit steady);
        return !steady && ($urandom_range(99) < 17);
    endfunction

    // Advances the model by one accepted word; returns 1 with the scan word it yields.
    function automatic bit predict_word(input logic [1:0] k, input logic [7:0] d,
                                        output result_t r);
        logic [INDEX_W-1:0] idx;
        logic [MODE_W-1:0]  md;
        idx = d[5:0];
        md  = d[7:6];
        r   = '0;
        case (k)
            KIND_SET_LED: begin
                phase_a[idx[5:3]][idx[2:0]] = md[1];
                phase_b[idx[5:3]][idx[2:0]] = md[0];
            end
            KIND_FLASH: begin
                flash_cnt = flash_cnt + 3'd1;
                if (lamp_left != 0) lamp_left = lamp_left - 4'd1;
            end
            KIND_SCAN: begin
                cur_row      = cur_row + 2'd1;
                r.row        = cur_row;
                r.row_enable = leds_en;
                if (lamp_left != 0)
                    r.column_bits = '1;
                else if (flash_cnt[2])
                    r.column_bits = {phase_b[{cur_row, 1'b1}], phase_b[{cur_row, 1'b0}]};
                else
                    r.column_bits = {phase_a[{cur_row, 1'b1}], phase_a[{cur_row, 1'b0}]};
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void check_scan_word(input logic [M_TDATA_W-1:0] word);
        result_t got;
        result_t want;
        got.row         = word[1:0];
        got.column_bits = word[17:2];
        got.row_enable  = word[18];
        if (scan_rows_due.size() == 0) begin
            $display("%0t: unexpected scan word: row %0d cols %h en %b", $time,
                     got.row, got.column_bits, got.row_enable);
            mismatches++;
        end else begin
            want = scan_rows_due.pop_front();
            if (got !== want || word[23:19] !== 5'd0) begin
                $display("%0t: scan word mismatch: expected row %0d cols %h en %b pad 00",
                         $time, want.row, want.column_bits, want.row_enable);
                $display("%0t:                     actual   row %0d cols %h en %b pad %h",
                         $time, got.row, got.column_bits, got.row_enable, word[23:19]);
                mismatches++;
            end
        end
    endfunction

    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_scan_word(m_tdata);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !idle_now(rx_steady);
            end
        end
    end

    task automatic send_word(input logic [1:0] k, input logic [7:0] d,
                             input bit has_res, input result_t fixed_res);
        result_t r;
        while (idle_now(tx_steady)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        if (predict_word(k, d, r)) scan_rows_due.push_back(has_res ? fixed_res : r);
    endtask

    task automatic drain_scans(input int unsigned extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (scan_rows_due.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_LEDS_EN) leds_en = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {31'd0, leds_en}) begin
            $display("%0t: leds_enabled read mismatch: expected %h actual %h", $time,
                     {31'd0, leds_en}, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [1:0] pick_kind(input int unsigned scan_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return KIND_SPARE;
        if (roll < 5 + scan_pct) return KIND_SCAN;
        if (roll < 25 + scan_pct) return KIND_FLASH;
        return KIND_SET_LED;
    endfunction

    initial begin
        logic [1:0] kind;
        foreach (phase_a[i]) begin
            phase_a[i] = '0;
            phase_b[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_read_check(ADDR_LEDS_EN);

        foreach (dir_rows[i])
            send_word(dir_rows[i].kind, {dir_rows[i].mode, dir_rows[i].idx},
                      dir_rows[i].has_res, dir_rows[i].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_scans(SETTLE_CYCLES);
            apb_write(ADDR_LEDS_EN, cfg_words[ph]);
            apb_write(ADDR_SPARE, ~cfg_words[ph]);
            apb_read_check(ADDR_LEDS_EN);
            tx_steady = (ph == 3);
            rx_steady = (ph == 3);
            // long output stall with scan-heavy input: fills the block
            if (ph == 1) rx_hold_req = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (ph == 2 && n == 100) drain_scans(0);
                kind = pick_kind((ph == 1 && n < 60) ? 70 : 35);
                send_word(kind, 8'($urandom_range(255)), 1'b0, NO_ROW);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_scans(10);

        if (mismatches == 0 && scan_rows_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
